// File: src/cstc_pkg.sv
// Shared types and constants for the cross stencil threshold counter.
// Used by the raster scan, the stencil evaluator and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cstc_pkg;

  // fixed field widths of the stream and configuration ports
  localparam int PIX_IN_W    = 8;
  localparam int COUNT_W     = 12;
  localparam int OUT_TDATA_W = 16;
  localparam int SIZE_W      = 7;
  localparam int THR_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

  // reset values and the smallest frame edge
  localparam logic [SIZE_W-1:0] COLUMNS_RESET   = 7'd8;
  localparam logic [SIZE_W-1:0] ROWS_RESET      = 7'd6;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 11'd30;
  localparam logic [SIZE_W-1:0] MIN_SIZE        = 7'd3;

  // per-pixel control flags passed from the scan stage to the evaluator
  typedef struct packed {
    logic first_col;
    logic eligible;
    logic frame_end;
  } stage_flags_t;

endpackage

`default_nettype wire

// File: src/cstc_ram.sv
// Generic simple RAM: one write port, two read ports, registered read data.
// Holds the two line stores of the stencil. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cstc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]                         rd_data_a,
  output logic [WIDTH-1:0]                         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports, held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// File: src/cstc_scan.sv
// Raster scan stage: tracks row and column of the incoming pixel, issues
// line store reads and registers the pixel with its flags. Uses cstc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cstc_scan import cstc_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [PIX_IN_W-1:0] s_tdata,
  input  logic [SIZE_W-1:0]   image_columns,
  input  logic [SIZE_W-1:0]   image_rows,
  input  logic                hold,
  output logic                rd_en,
  output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] rd_addr_a,
  output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] rd_addr_b,
  output logic                s1_valid,
  output stage_flags_t        s1_flags,
  output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] s1_col,
  output logic [((PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W)-1:0] s1_pix
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int PW    = (PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W;
  localparam int CW1   = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
  localparam int RW1   = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [CW1-1:0]   cols_eff;
  logic [RW1-1:0]   rows_eff;
  logic [CW1-1:0]   col_inc;
  logic [RW1-1:0]   row_inc;
  logic             last_col;
  logic             last_row;
  logic             row_ok;
  logic             accept;
  stage_flags_t     flags;

  // clamp the configured frame size to the supported range
  always_comb begin
    if (image_columns < MIN_SIZE) begin
      cols_eff = CW1'(MIN_SIZE);
    end else if (CW1'(image_columns) > CW1'(MAX_COLUMNS)) begin
      cols_eff = CW1'(MAX_COLUMNS);
    end else begin
      cols_eff = CW1'(image_columns);
    end
    if (image_rows < MIN_SIZE) begin
      rows_eff = RW1'(MIN_SIZE);
    end else if (RW1'(image_rows) > RW1'(MAX_ROWS)) begin
      rows_eff = RW1'(MAX_ROWS);
    end else begin
      rows_eff = RW1'(image_rows);
    end
  end

  // position decode for the pixel on the input
  always_comb begin
    col_inc         = CW1'(col) + CW1'(1);
    row_inc         = RW1'(row) + RW1'(1);
    last_col        = (col_inc >= cols_eff);
    last_row        = (row_inc >= rows_eff);
    row_ok          = (RW1'(row) >= RW1'(2)) && (RW1'(row) < rows_eff);
    flags.first_col = (col == '0);
    flags.eligible  = row_ok && (col != '0) && !last_col;
    flags.frame_end = last_col && last_row;
  end

  assign s_tready = !hold;
  assign accept   = s_tvalid && s_tready;

  // line store reads for this column and the one to its right
  assign rd_en     = accept;
  assign rd_addr_a = col;
  assign rd_addr_b = (col == COL_W'(MAX_COLUMNS - 1)) ? '0 : col + COL_W'(1);

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        if (last_row) begin
          row <= '0;
        end else begin
          row <= ROW_W'(row_inc);
        end
      end else begin
        col <= COL_W'(col_inc);
      end
    end
  end

  // stage register toward the evaluator, held while it stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!hold) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags <= flags;
      s1_col   <= col;
      s1_pix   <= s_tdata[PW-1:0];
    end
  end

  // a read never hits the entry that the evaluator writes back in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    rd_en && s1_valid && !hold |-> (rd_addr_a != s1_col) && (rd_addr_b != s1_col))
    else $error("line store read collides with write back");

  // the row always wraps to column zero
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && last_col |=> col == '0)
    else $error("column did not wrap at end of row");

  // the last pixel of a frame is never a stencil position
  a_frame_end_not_eligible: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_flags.frame_end |-> !s1_flags.eligible)
    else $error("frame end pixel flagged as stencil position");

endmodule

`default_nettype wire

// File: src/cstc_eval.sv
// Stencil evaluator: forms the cross sum from the line store data, counts
// hits, writes the rows back and holds the frame result. Uses cstc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cstc_eval import cstc_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s1_valid,
  input  stage_flags_t           s1_flags,
  input  logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] s1_col,
  input  logic [((PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W)-1:0] s1_pix,
  input  logic [2*((PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W)-1:0] rd_data_a,
  input  logic [2*((PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W)-1:0] rd_data_b,
  input  logic [THR_W-1:0]       star_threshold,
  output logic                   hold,
  output logic                   wr_en,
  output logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] wr_addr,
  output logic [2*((PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W)-1:0] wr_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int PW    = (PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W;
  localparam int SUM_W = (PW + 3 > THR_W) ? PW + 3 : THR_W;

  logic [PW-1:0]      up_c;
  logic [PW-1:0]      mid_c;
  logic [PW-1:0]      mid_right;
  logic [PW-1:0]      mid_left;
  logic [PW-1:0]      left_eff;
  logic [SUM_W-1:0]   sum;
  logic               hit;
  logic               fire;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] out_count;

  // line store entry layout: upper row in the high half, middle row low
  assign up_c      = rd_data_a[2*PW-1:PW];
  assign mid_c     = rd_data_a[PW-1:0];
  assign mid_right = rd_data_b[PW-1:0];
  assign left_eff  = s1_flags.first_col ? '0 : mid_left;

  // cross sum and threshold compare
  always_comb begin
    sum = SUM_W'(up_c) + SUM_W'(left_eff) + SUM_W'(mid_c) + SUM_W'(mid_right)
        + SUM_W'(s1_pix);
    hit = s1_flags.eligible && (sum > SUM_W'(star_threshold));
    count_next = count + COUNT_W'(hit);
  end

  // stall only when a frame result meets a result not yet taken
  assign hold = s1_valid && s1_flags.frame_end && m_tvalid && !m_tready;
  assign fire = s1_valid && !hold;

  // write back: middle row moves up, new pixel becomes the middle row
  assign wr_en   = fire;
  assign wr_addr = s1_col;
  assign wr_data = {mid_c, s1_pix};

  // left neighbor is the middle row value read for the previous column
  always_ff @(posedge clk) begin
    if (fire) begin
      mid_left <= mid_c;
    end
  end

  // running count of the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      if (s1_flags.frame_end) begin
        count <= '0;
      end else begin
        count <= count_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && s1_flags.frame_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_flags.frame_end) begin
      out_count <= count_next;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - COUNT_W){1'b0}}, out_count};

  // a stalled pixel must not be counted twice
  a_hold_keeps_count: assert property (@(posedge clk) disable iff (rst)
    hold |=> $stable(count))
    else $error("count changed while stage stalled");

  // end of frame raises a result and restarts the count
  a_frame_result: assert property (@(posedge clk) disable iff (rst)
    fire && s1_flags.frame_end |=> m_tvalid && (count == '0))
    else $error("frame end did not produce a result");

  // border pixels never move the count
  a_border_no_count: assert property (@(posedge clk) disable iff (rst)
    fire && !s1_flags.eligible && !s1_flags.frame_end |=> count == $past(count))
    else $error("count moved on a border pixel");

endmodule

`default_nettype wire

// File: src/cross_stencil_threshold_counter_unit.sv
// Cross stencil threshold counter, top level. Takes one pixel per clock in
// raster order while the input is not stalled; the scan stage and evaluator
// take a new pixel while passing the last on, and the single line store RAM
// is read once (two ports) and written once per pixel. The last pixel of a
// frame passes the scan stage register, then the evaluator loads the frame
// count into the result register. The input stalls only while a finished
// count waits for the result port and the next frame has already reached its
// last pixel. The line stores need no clearing after reset; counting positions
// start in the third row, once both rows above have been written.
// Depends on cstc_pkg, cstc_scan, cstc_eval and cstc_ram.
`timescale 1ns / 1ps
`default_nettype none

module cross_stencil_threshold_counter_unit import cstc_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int PIXEL_BITS  = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [PIX_IN_W-1:0]    s_tdata,   // [7:0] pixel_value
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [11:0] star_count, [15:12] zero
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int PW    = (PIXEL_BITS < PIX_IN_W) ? PIXEL_BITS : PIX_IN_W;

  logic [SIZE_W-1:0] image_columns;
  logic [SIZE_W-1:0] image_rows;
  logic [THR_W-1:0]  star_threshold;

  logic              hold;
  logic              rd_en;
  logic [COL_W-1:0]  rd_addr_a;
  logic [COL_W-1:0]  rd_addr_b;
  logic [2*PW-1:0]   rd_data_a;
  logic [2*PW-1:0]   rd_data_b;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [2*PW-1:0]   wr_data;
  logic              s1_valid;
  stage_flags_t      s1_flags;
  logic [COL_W-1:0]  s1_col;
  logic [PW-1:0]     s1_pix;

  // configuration registers, writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_columns  <= COLUMNS_RESET;
      image_rows     <= ROWS_RESET;
      star_threshold <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLUMNS:   image_columns  <= cfg_data[SIZE_W-1:0];
        CFG_ROWS:      image_rows     <= cfg_data[SIZE_W-1:0];
        CFG_THRESHOLD: star_threshold <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // raster scan and read issue
  cstc_scan #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .image_columns (image_columns),
    .image_rows    (image_rows),
    .hold          (hold),
    .rd_en         (rd_en),
    .rd_addr_a     (rd_addr_a),
    .rd_addr_b     (rd_addr_b),
    .s1_valid      (s1_valid),
    .s1_flags      (s1_flags),
    .s1_col        (s1_col),
    .s1_pix        (s1_pix)
  );

  // both line stores, one entry per column
  cstc_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // cross sum, count and result
  cstc_eval #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_eval (
    .clk            (clk),
    .rst            (rst),
    .s1_valid       (s1_valid),
    .s1_flags       (s1_flags),
    .s1_col         (s1_col),
    .s1_pix         (s1_pix),
    .rd_data_a      (rd_data_a),
    .rd_data_b      (rd_data_b),
    .star_threshold (star_threshold),
    .hold           (hold),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for the cross stencil threshold counter: streams pixel frames and
// register writes into the unit and checks every frame count on the result port.
// Depends on cstc_pkg and cross_stencil_threshold_counter_unit.
`timescale 1ns / 1ps

module tb;
  import cstc_pkg::*;

  localparam int MAX_EDGE          = 64;
  localparam int RANDOM_ITEMS      = 200;
  localparam int MIN_RANDOM_FRAMES = 5;
  localparam int SETTLE_CYCLES     = 4;
  localparam int LONG_HOLD         = 90;
  localparam int FLOOD_PIXELS      = 45;
  localparam int WATCHDOG_LIMIT    = 2000;

  // index with no register behind it, written to show it is ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum {PAT_FULL, PAT_DARK, PAT_RANDOM, PAT_CHECKER, PAT_SPARSE} pix_pattern_t;

  // one directed frame: register writes (-1 keeps the register), pixel pattern,
  // optional size change after split_at pixels, and a typed count (-1 predicted)
  typedef struct {
    int           cols_wr;
    int           rows_wr;
    int           thr_wr;
    int           poke_unused;
    pix_pattern_t pat;
    int           split_at;
    int           split_cols;
    int           split_rows;
    int           pinned;
  } frame_case_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [PIX_IN_W-1:0]    s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cross_stencil_threshold_counter_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // stencil predictor state
  logic [PIX_IN_W-1:0] upper_line  [MAX_EDGE];
  logic [PIX_IN_W-1:0] middle_line [MAX_EDGE];
  logic [PIX_IN_W-1:0] win_left, win_mid, win_right;
  int unsigned         row_pos, col_pos;
  logic [COUNT_W-1:0]  star_tally;
  logic [SIZE_W-1:0]   shadow_cols, shadow_rows;
  logic [THR_W-1:0]    shadow_thr;

  // frame counts still owed by the unit, oldest first
  logic [COUNT_W-1:0]  pending_counts [$];
  logic [COUNT_W-1:0]  owed_count;

  int frame_ends   = 0;
  int pinned_count = -1;
  int items_sent   = 0;
  int fail_count   = 0;
  int idle_cycles  = 0;
  bit hold_req     = 1'b0;
  bit result_taken = 1'b0;
  bit tx_burst     = 1'b0;
  bit rx_burst     = 1'b0;

  frame_case_t directed_cases [14] = '{
    // reset sizes, bright frame: all 24 interior positions count
    '{-1, -1, -1, 0, PAT_FULL, 0, -1, -1, 24},
    // width clamps to 64, height clamps to 3; fills both line stores
    '{127, 2, 2047, 0, PAT_FULL, 0, -1, -1, 0},
    // width clamps to 3, height clamps to 64; zero sum never exceeds zero
    '{0, 127, 0, 0, PAT_DARK, 0, -1, -1, 0},
    // widest frame, every position of the middle row counts
    '{64, 3, 1274, 0, PAT_FULL, 0, -1, -1, 62},
    // sum equal to threshold does not count
    '{3, 3, 1275, 1, PAT_FULL, 0, -1, -1, 0},
    '{-1, -1, 1274, 0, PAT_FULL, 0, -1, -1, 1},
    '{2, 1, 0, 0, PAT_RANDOM, 0, -1, -1, -1},
    '{9, 4, 700, 0, PAT_RANDOM, 0, -1, -1, -1},
    '{5, 4, 600, 0, PAT_RANDOM, 0, -1, -1, -1},
    '{7, 5, 500, 0, PAT_CHECKER, 0, -1, -1, -1},
    '{4, 8, 100, 0, PAT_SPARSE, 0, -1, -1, -1},
    // width shrinks below the current column mid-row
    '{8, 5, 400, 0, PAT_RANDOM, 20, 3, -1, -1},
    // height shrinks below the current row mid-frame
    '{6, 7, 400, 0, PAT_RANDOM, 27, -1, 3, -1},
    // both sizes grow mid-frame
    '{4, 4, 300, 0, PAT_RANDOM, 6, 9, 6, -1}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_edge(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // take one pixel into the stencil model, queue the count at frame end
  task automatic advance_stencil(input logic [PIX_IN_W-1:0] pix);
    int unsigned cols, rows, c, cross_sum;
    bit          last_col;
    cols     = clamp_edge(shadow_cols, MAX_EDGE);
    rows     = clamp_edge(shadow_rows, MAX_EDGE);
    c        = col_pos;
    last_col = (c + 1 >= cols);

    win_left  = (c >= 1) ? win_mid : '0;
    win_mid   = middle_line[c];
    win_right = (c + 1 < MAX_EDGE) ? middle_line[c + 1] : '0;
    if (row_pos >= 2 && row_pos < rows && c >= 1 && !last_col) begin
      cross_sum = upper_line[c] + win_left + win_mid + win_right + pix;
      if (cross_sum > shadow_thr) star_tally = star_tally + 1'b1;
    end
    upper_line[c]  = middle_line[c];
    middle_line[c] = pix;

    if (!last_col) begin
      col_pos = c + 1;
    end else begin
      col_pos = 0;
      if (row_pos + 1 >= rows) begin
        pending_counts.push_back(pinned_count >= 0 ? COUNT_W'(pinned_count) : star_tally);
        frame_ends++;
        row_pos    = 0;
        star_tally = '0;
      end else begin
        row_pos++;
      end
    end
  endtask

  // predictor update and result check on every accepted request
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_EDGE; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      win_left    = '0;
      win_mid     = '0;
      win_right   = '0;
      row_pos     = 0;
      col_pos     = 0;
      star_tally  = '0;
      shadow_cols = COLUMNS_RESET;
      shadow_rows = ROWS_RESET;
      shadow_thr  = THRESHOLD_RESET;
      idle_cycles = 0;
    end else begin
      if (s_tvalid && s_tready) advance_stencil(s_tdata);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COLUMNS:   shadow_cols = cfg_data[SIZE_W-1:0];
          CFG_ROWS:      shadow_rows = cfg_data[SIZE_W-1:0];
          CFG_THRESHOLD: shadow_thr  = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        result_taken = 1'b1;
        if (pending_counts.size() == 0) begin
          $error("star_count: result with nothing expected, actual %0d",
                 m_tdata[COUNT_W-1:0]);
          fail_count++;
        end else begin
          owed_count = pending_counts.pop_front();
          if (m_tdata[COUNT_W-1:0] !== owed_count) begin
            $error("star_count mismatch: expected %0d, actual %0d",
                   owed_count, m_tdata[COUNT_W-1:0]);
            fail_count++;
          end
          if (m_tdata[OUT_TDATA_W-1:COUNT_W] !== '0) begin
            $error("tdata padding mismatch: expected 0, actual %0d",
                   m_tdata[OUT_TDATA_W-1:COUNT_W]);
            fail_count++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  function automatic int draw_gap(input bit burst);
    if (burst) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 16);
    return $urandom_range(0, 2);
  endfunction

  // frame edge value, mostly small, with rare clamped and large ones and
  // random bits above the register width
  function automatic int draw_edge(input int typ_hi, input int mid_hi);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 78)      v = $urandom_range(3, typ_hi);
    else if (r < 88) v = $urandom_range(0, 2);
    else if (r < 96) v = $urandom_range(typ_hi + 1, mid_hi);
    else             v = $urandom_range(mid_hi + 1, 127);
    if ($urandom_range(0, 3) == 0) v = v | ($urandom_range(1, 15) << SIZE_W);
    return v;
  endfunction

  function automatic int draw_threshold();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(300, 900);
    if (r < 7) return $urandom_range(0, 2047);
    if (r < 9) return $urandom_range(0, 150);
    return $urandom_range(1270, 1280);
  endfunction

  function automatic logic [PIX_IN_W-1:0] pattern_pixel(input pix_pattern_t pat, input int idx);
    case (pat)
      PAT_FULL:    return '1;
      PAT_DARK:    return '0;
      PAT_CHECKER: return idx[0] ? '1 : '0;
      PAT_SPARSE:  return ($urandom_range(0, 7) == 0) ? PIX_IN_W'($urandom_range(128, 255))
                                                      : PIX_IN_W'($urandom_range(0, 15));
      default:     return PIX_IN_W'($urandom_range(0, 255));
    endcase
  endfunction

  // entered and left just after a falling edge
  task automatic drive_pixel(input logic [PIX_IN_W-1:0] pix);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending until every owed count is back and the pipeline is empty
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending_counts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic setup_frame(input int cols, input int rows, input int thr, input bit poke);
    settle();
    if (cols >= 0) write_reg(CFG_COLUMNS, cols);
    if (rows >= 0) write_reg(CFG_ROWS, rows);
    if (thr >= 0)  write_reg(CFG_THRESHOLD, thr);
    if (poke)      write_reg(CFG_UNUSED, $urandom_range(0, 2047));
    cfg_valid = 1'b0;
  endtask

  // send pixels until the frame closes, resizing after split_at pixels if asked
  task automatic run_frame(input pix_pattern_t pat, input int split_at,
                           input int split_cols, input int split_rows);
    int target, idx;
    target = frame_ends + 1;
    idx    = 0;
    while (frame_ends < target) begin
      if (split_at > 0 && idx == split_at) setup_frame(split_cols, split_rows, -1, 1'b0);
      drive_pixel(pattern_pixel(pat, idx));
      idx++;
    end
  endtask

  // small frames sent back to back while the receiver is held off
  task automatic flood_held_receiver();
    setup_frame(MIN_SIZE, MIN_SIZE, $urandom_range(300, 900), 1'b0);
    hold_req = 1'b1;
    tx_burst = 1'b1;
    repeat (FLOOD_PIXELS) drive_pixel(PIX_IN_W'($urandom_range(0, 255)));
    tx_burst = 1'b0;
  endtask

  // result side: random stall after each request, long hold-off on demand
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req     = 1'b0;
        result_taken = 1'b0;
        stall_left   = LONG_HOLD;
      end else if (result_taken) begin
        result_taken = 1'b0;
        stall_left   = draw_gap(rx_burst);
        if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
      end
      m_tready = (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // no request of any kind for too long
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  initial begin
    frame_case_t  fc;
    pix_pattern_t pat;
    int           r, split_at, frame_px, random_base;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_COLUMNS;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed frames
    foreach (directed_cases[i]) begin
      fc = directed_cases[i];
      setup_frame(fc.cols_wr, fc.rows_wr, fc.thr_wr, fc.poke_unused != 0);
      pinned_count = fc.pinned;
      run_frame(fc.pat, fc.split_at, fc.split_cols, fc.split_rows);
      pinned_count = -1;
    end

    flood_held_receiver();

    // random frames
    items_sent  = 0;
    random_base = frame_ends;
    while (items_sent < RANDOM_ITEMS || frame_ends - random_base < MIN_RANDOM_FRAMES) begin
      if ($urandom_range(0, 39) == 0) flood_held_receiver();
      r = $urandom_range(0, 9);
      if (r < 4)
        setup_frame(draw_edge(6, 20), draw_edge(5, 10), draw_threshold(),
                    $urandom_range(0, 19) == 0);
      else if (r < 6)
        setup_frame(-1, -1, draw_threshold(), 1'b0);
      tx_burst = ($urandom_range(0, 3) == 0);
      pat      = pix_pattern_t'($urandom_range(0, 4));
      split_at = 0;
      if ($urandom_range(0, 6) == 0) begin
        frame_px = clamp_edge(shadow_cols, MAX_EDGE) * clamp_edge(shadow_rows, MAX_EDGE);
        split_at = $urandom_range(1, frame_px - 1);
      end
      run_frame(pat, split_at, draw_edge(6, 20),
                $urandom_range(0, 1) ? draw_edge(5, 10) : -1);
      tx_burst = 1'b0;
    end

    settle();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
